// ----- rtl/npc_pkg.sv -----
// Shared types and constants for the nearest palette colour search.
`timescale 1ns / 1ps

package npc_pkg;

    localparam int CHAN_W     = 8;
    localparam int IDX_W      = 4;
    localparam int SQ_W       = 2 * CHAN_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int COUNT_W    = 5;
    localparam int PLANES_W   = 3;
    localparam int MAX_SEARCH = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_PLANE_COUNT = 1'b1;

    // One word travelling down the cell chain, with the running best match.
    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              found;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
    } tok_t;

endpackage

// ----- rtl/npc_cell.sv -----
// One palette entry cell: holds the entry and updates the passing best match.
`timescale 1ns / 1ps

module npc_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic [npc_pkg::COUNT_W-1:0]  search_count,
    input  npc_pkg::tok_t                tok_in,
    output npc_pkg::tok_t                tok_out
);

    logic [3*npc_pkg::CHAN_W-1:0] entry_reg;
    npc_pkg::tok_t                mid_reg;
    npc_pkg::tok_t                out_reg;
    logic                         hit_reg;
    logic [npc_pkg::SQ_W-1:0]     sq_r_reg;
    logic [npc_pkg::SQ_W-1:0]     sq_g_reg;
    logic [npc_pkg::SQ_W-1:0]     sq_b_reg;

    logic [npc_pkg::CHAN_W-1:0]   ent_r;
    logic [npc_pkg::CHAN_W-1:0]   ent_g;
    logic [npc_pkg::CHAN_W-1:0]   ent_b;
    logic [npc_pkg::CHAN_W-1:0]   dr;
    logic [npc_pkg::CHAN_W-1:0]   dg;
    logic [npc_pkg::CHAN_W-1:0]   db;
    logic                         hit_next;
    logic                         load_entry;
    logic [npc_pkg::DIST_W-1:0]   dist_sum;
    logic                         take;
    npc_pkg::tok_t                out_next;

    assign ent_r = entry_reg[3*npc_pkg::CHAN_W-1:2*npc_pkg::CHAN_W];
    assign ent_g = entry_reg[2*npc_pkg::CHAN_W-1:npc_pkg::CHAN_W];
    assign ent_b = entry_reg[npc_pkg::CHAN_W-1:0];

    assign dr = (tok_in.red   >= ent_r) ? tok_in.red   - ent_r : ent_r - tok_in.red;
    assign dg = (tok_in.green >= ent_g) ? tok_in.green - ent_g : ent_g - tok_in.green;
    assign db = (tok_in.blue  >= ent_b) ? tok_in.blue  - ent_b : ent_b - tok_in.blue;

    assign hit_next = tok_in.valid && (tok_in.cmd == npc_pkg::CMD_MATCH)
                      && (npc_pkg::COUNT_W'(CELL_ID) < search_count);
    assign load_entry = tok_in.valid && (tok_in.cmd == npc_pkg::CMD_WRITE)
                        && (tok_in.idx == npc_pkg::IDX_W'(CELL_ID));

    // Stage one: load the entry on a write, square the channel differences.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            mid_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (load_entry)
            begin
                entry_reg <= {tok_in.red, tok_in.green, tok_in.blue};
            end
            mid_reg <= tok_in;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_r_reg <= dr * dr;
            sq_g_reg <= dg * dg;
            sq_b_reg <= db * db;
        end
    end

    // Stage two: sum and compare; strictly smaller wins, so ties keep the lower index.
    always_comb
    begin
        dist_sum = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                   + npc_pkg::DIST_W'(sq_b_reg);
        take = hit_reg && (!mid_reg.found || (dist_sum < mid_reg.best_dist));
        out_next = mid_reg;
        if (take)
        begin
            out_next.found     = 1'b1;
            out_next.best_dist = dist_sum;
            out_next.best_idx  = npc_pkg::IDX_W'(CELL_ID);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign tok_out = out_reg;

endmodule

// ----- rtl/nearest_palette_colour.sv -----
// Top level of the nearest palette colour search: cell chain and output register.
`timescale 1ns / 1ps

// Nearest palette colour search over a chain of entry cells.
// Request channel (req_valid/req_stall): cmd selects a write, which loads
// red/green/blue into entry entry_index, or a match, which asks for the
// entry nearest to red/green/blue by squared distance, lowest index on ties.
// Response channel (rsp_valid/rsp_stall): one best_index word per match;
// writes give no response. Entries past the searched count (the smaller of
// entry_count, 2^plane_count and the cell count) are skipped; with none
// searched the answer is 0.
// Each cell holds one entry and takes two register stages; an output
// register follows the chain. Words march down the chain in order, so a
// write always lands before any later match reads it. Throughput is one
// word per cycle unless rsp_stall holds the chain. The user must write
// configuration (cfg_we/cfg_index/cfg_data) only while idle; the block
// does not enforce this. Reset clears the palette to zero, entry_count
// to 16 and plane_count to 4. When rsp_valid is held with rsp_stall high
// the whole chain holds and req_stall rises; nothing is dropped.
module nearest_palette_colour #(
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [npc_pkg::COUNT_W-1:0]    cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           cmd,
    input  logic [npc_pkg::IDX_W-1:0]      entry_index,
    input  logic [npc_pkg::CHAN_W-1:0]     red,
    input  logic [npc_pkg::CHAN_W-1:0]     green,
    input  logic [npc_pkg::CHAN_W-1:0]     blue,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [npc_pkg::IDX_W-1:0]      best_index
);

    // Only the first 16 entries are addressable or searchable.
    localparam int CELLS = (PALETTE_ENTRIES < npc_pkg::MAX_SEARCH)
                           ? PALETTE_ENTRIES : npc_pkg::MAX_SEARCH;

    logic [npc_pkg::COUNT_W-1:0]  entry_count_reg;
    logic [npc_pkg::PLANES_W-1:0] plane_count_reg;
    logic                         rsp_valid_reg;
    logic [npc_pkg::IDX_W-1:0]    best_index_reg;

    logic                         advance;
    logic [npc_pkg::COUNT_W-1:0]  plane_limit;
    logic [npc_pkg::COUNT_W-1:0]  search_count;
    npc_pkg::tok_t                chain [CELLS+1];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= npc_pkg::COUNT_W'(16);
            plane_count_reg <= npc_pkg::PLANES_W'(4);
        end
        else if (cfg_we)
        begin
            priority if (cfg_index == npc_pkg::REG_ENTRY_COUNT)
            begin
                entry_count_reg <= cfg_data;
            end
            else
            begin
                plane_count_reg <= cfg_data[npc_pkg::PLANES_W-1:0];
            end
        end
    end

    // Searched count: saturate 2^plane_count at 16, then clip to entries and cells.
    always_comb
    begin
        if (plane_count_reg >= npc_pkg::PLANES_W'(4))
        begin
            plane_limit = npc_pkg::COUNT_W'(npc_pkg::MAX_SEARCH);
        end
        else
        begin
            plane_limit = npc_pkg::COUNT_W'(1) << plane_count_reg;
        end
        search_count = (entry_count_reg < plane_limit) ? entry_count_reg : plane_limit;
        if (search_count > npc_pkg::COUNT_W'(CELLS))
        begin
            search_count = npc_pkg::COUNT_W'(CELLS);
        end
    end

    // Advance the chain unless a finished answer is held back by the receiver.
    assign advance   = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !advance;

    // Head of the chain: the incoming word with an empty best match.
    always_comb
    begin
        chain[0]           = '0;
        chain[0].valid     = req_valid;
        chain[0].cmd       = cmd;
        chain[0].idx       = entry_index;
        chain[0].red       = red;
        chain[0].green     = green;
        chain[0].blue      = blue;
    end

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        npc_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .search_count (search_count),
            .tok_in       (chain[i]),
            .tok_out      (chain[i+1])
        );
    end

    // Output register: keep matches, drop writes at the tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= chain[CELLS].valid && (chain[CELLS].cmd == npc_pkg::CMD_MATCH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            best_index_reg <= chain[CELLS].best_idx;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign best_index = best_index_reg;

endmodule
